// ===== rtl/gha_pkg.sv =====
// shared types, codes and helpers for the generational handle allocator
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

   localparam int OCC_W     = 16;
   localparam int OCC_BIT_W = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NULL = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [31:0] resource_ref;
      logic [7:0]  slot_index;
      logic        handle_is_null;
   } req_type;

   typedef struct packed {
      logic [7:0]  handle_index;
      logic [31:0] handle_generation;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] generation;
      logic [15:0] refcount;
      logic [31:0] resource;
   } entry_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2
   } act_type;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_UPDATE  = 5'b00100,
      ST_SCAN    = 5'b01000,
      ST_DELIVER = 5'b10000
   } state_type;

   // lowest set bit: msb is the found flag, the rest the bit position
   function automatic logic [OCC_BIT_W:0] first_set(input logic [OCC_W-1:0] v);
      logic [OCC_BIT_W:0] r;
      r = '0;
      for (int b = OCC_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            r = {1'b1, OCC_BIT_W'(b)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gha_ram.sv =====
// single write port, single registered read port memory
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int WIDTH  = 80
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// top level: slot table control, first-free tracking and result register
//
// channel  direction  handshake             payload
// req_     in         req_valid/req_stall   gha_pkg::req_type
// rsp_     out        rsp_valid/rsp_stall   gha_pkg::rsp_type
//
// remove goes from accept via ST_UPDATE to ST_DELIVER, which loads the result register;
//    null remove, out-of-range remove and full insert go straight to ST_DELIVER
// insert goes via ST_UPDATE, then ST_SCAN for each further 16-slot occupancy word
//    scanned for the next free slot, at most (SLOTS+15)/16-1 words, then ST_DELIVER
// after reset a clearing pass over all SLOTS slots zeroes both memories; req_stall is high
// a stalled result sits in the output register while the next transaction is taken
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator #(
   parameter int SLOTS = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire gha_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output gha_pkg::rsp_type      rsp_payload
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FF_W   = $clog2(SLOTS + 1);
   localparam int WORDS  = (SLOTS + gha_pkg::OCC_W - 1) / gha_pkg::OCC_W;
   localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SX_W   = IDX_W + gha_pkg::OCC_BIT_W;
   localparam int ENT_W  = $bits(gha_pkg::entry_type);

   gha_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [FF_W-1:0]     first_free_ff, first_free_in;
   gha_pkg::act_type    act_ff, act_in;
   logic [IDX_W-1:0]    tgt_ff, tgt_in;
   logic [31:0]         ref_ff, ref_in;
   logic [WORD_W-1:0]   scan_word_ff, scan_word_in;
   gha_pkg::rsp_type    res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   gha_pkg::rsp_type    rsp_ff, rsp_in;

   logic                        ent_we;
   logic [IDX_W-1:0]            ent_waddr, ent_raddr;
   gha_pkg::entry_type          ent_wdata, ent_rdata;
   logic                        occ_we;
   logic [WORD_W-1:0]           occ_waddr, occ_raddr;
   logic [gha_pkg::OCC_W-1:0]   occ_wdata, occ_rdata;

   logic [IDX_W-1:0]              req_tgt;
   logic [gha_pkg::OCC_W-1:0]     word_new;
   logic [gha_pkg::OCC_W-1:0]     cand;
   logic [gha_pkg::OCC_BIT_W:0]   enc;
   logic [WORD_W-1:0]             cur_word;

   function automatic logic [WORD_W-1:0] word_of(input logic [IDX_W-1:0] s);
      logic [SX_W-1:0] x;
      x = SX_W'(s);
      return WORD_W'(x >> gha_pkg::OCC_BIT_W);
   endfunction

   function automatic logic [gha_pkg::OCC_BIT_W-1:0] bit_of(input logic [IDX_W-1:0] s);
      logic [SX_W-1:0] x;
      x = SX_W'(s);
      return x[gha_pkg::OCC_BIT_W-1:0];
   endfunction

   // slots that exist in a word
   function automatic logic [gha_pkg::OCC_W-1:0] vmask(input logic [WORD_W-1:0] w);
      logic [gha_pkg::OCC_W-1:0] m;
      for (int b = 0; b < gha_pkg::OCC_W; b++) begin
         m[b] = ((int'(w) * gha_pkg::OCC_W + b) < SLOTS);
      end
      return m;
   endfunction

   // slots strictly above a bit position
   function automatic logic [gha_pkg::OCC_W-1:0] above(
      input logic [gha_pkg::OCC_BIT_W-1:0] p
   );
      logic [gha_pkg::OCC_W-1:0] m;
      for (int b = 0; b < gha_pkg::OCC_W; b++) begin
         m[b] = (b > int'(p));
      end
      return m;
   endfunction

   gha_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W),
      .WIDTH  (ENT_W)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   gha_ram #(
      .DEPTH  (WORDS),
      .ADDR_W (WORD_W),
      .WIDTH  (gha_pkg::OCC_W)
   ) u_occ_ram (
      .clock (clock),
      .we    (occ_we),
      .waddr (occ_waddr),
      .wdata (occ_wdata),
      .raddr (occ_raddr),
      .rdata (occ_rdata)
   );

   assign req_stall   = (state_ff != gha_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_tgt = (req_payload.operation == gha_pkg::OP_INSERT) ?
                    first_free_ff[IDX_W-1:0] : IDX_W'(req_payload.slot_index);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      first_free_in = first_free_ff;
      act_in        = act_ff;
      tgt_in        = tgt_ff;
      ref_in        = ref_ff;
      scan_word_in  = scan_word_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ent_we        = 1'b0;
      ent_waddr     = tgt_ff;
      ent_wdata     = '0;
      ent_raddr     = req_tgt;
      occ_we        = 1'b0;
      occ_waddr     = word_of(tgt_ff);
      occ_wdata     = '0;
      occ_raddr     = word_of(req_tgt);
      word_new      = '0;
      cand          = '0;
      enc           = '0;
      cur_word      = word_of(tgt_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         gha_pkg::ST_CLEAR: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            occ_we    = (int'(clr_ff) < WORDS);
            occ_waddr = WORD_W'(clr_ff);
            if (clr_ff == IDX_W'(SLOTS - 1)) begin
               state_in = gha_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + IDX_W'(1);
            end
         end
         gha_pkg::ST_IDLE: begin
            if (req_valid) begin
               tgt_in = req_tgt;
               ref_in = req_payload.resource_ref;
               res_in = '0;
               act_in = gha_pkg::ACT_NONE;
               if (req_payload.operation == gha_pkg::OP_INSERT) begin
                  if (first_free_ff == FF_W'(SLOTS)) begin
                     res_in.status = gha_pkg::STATUS_FULL;
                  end else begin
                     act_in = gha_pkg::ACT_INSERT;
                  end
               end else if (req_payload.handle_is_null) begin
                  res_in.status = gha_pkg::STATUS_NULL;
               end else if (int'(req_payload.slot_index) < SLOTS) begin
                  act_in = gha_pkg::ACT_REMOVE;
               end
               state_in = (act_in == gha_pkg::ACT_NONE) ?
                          gha_pkg::ST_DELIVER : gha_pkg::ST_UPDATE;
            end
         end
         gha_pkg::ST_UPDATE: begin
            ent_we = 1'b1;
            occ_we = 1'b1;
            if (act_ff == gha_pkg::ACT_INSERT) begin
               ent_wdata.generation = ent_rdata.generation;
               ent_wdata.refcount   = 16'd1;
               ent_wdata.resource   = ref_ff;
               word_new  = occ_rdata | (gha_pkg::OCC_W'(1) << bit_of(tgt_ff));
               occ_wdata = word_new;
               res_in.handle_index      = 8'(tgt_ff);
               res_in.handle_generation = ent_rdata.generation;
               res_in.status            = gha_pkg::STATUS_DONE;
               cand = ~word_new & above(bit_of(tgt_ff)) & vmask(cur_word);
               enc  = gha_pkg::first_set(cand);
               if (enc[gha_pkg::OCC_BIT_W]) begin
                  first_free_in = FF_W'({cur_word, enc[gha_pkg::OCC_BIT_W-1:0]});
                  state_in      = gha_pkg::ST_DELIVER;
               end else if (cur_word == WORD_W'(WORDS - 1)) begin
                  first_free_in = FF_W'(SLOTS);
                  state_in      = gha_pkg::ST_DELIVER;
               end else begin
                  scan_word_in = cur_word + WORD_W'(1);
                  occ_raddr    = cur_word + WORD_W'(1);
                  state_in     = gha_pkg::ST_SCAN;
               end
            end else begin
               ent_wdata.generation = ent_rdata.generation + 32'd1;
               occ_wdata = occ_rdata & ~(gha_pkg::OCC_W'(1) << bit_of(tgt_ff));
               if (FF_W'(tgt_ff) < first_free_ff) begin
                  first_free_in = FF_W'(tgt_ff);
               end
               state_in = gha_pkg::ST_DELIVER;
            end
         end
         gha_pkg::ST_SCAN: begin
            cur_word = scan_word_ff;
            cand     = ~occ_rdata & vmask(scan_word_ff);
            enc      = gha_pkg::first_set(cand);
            if (enc[gha_pkg::OCC_BIT_W]) begin
               first_free_in = FF_W'({scan_word_ff, enc[gha_pkg::OCC_BIT_W-1:0]});
               state_in      = gha_pkg::ST_DELIVER;
            end else if (scan_word_ff == WORD_W'(WORDS - 1)) begin
               first_free_in = FF_W'(SLOTS);
               state_in      = gha_pkg::ST_DELIVER;
            end else begin
               scan_word_in = scan_word_ff + WORD_W'(1);
               occ_raddr    = scan_word_ff + WORD_W'(1);
            end
         end
         gha_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = gha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gha_pkg::ST_CLEAR;
         clr_ff        <= '0;
         first_free_ff <= '0;
         act_ff        <= gha_pkg::ACT_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         first_free_ff <= first_free_in;
         act_ff        <= act_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      ref_ff       <= ref_in;
      scan_word_ff <= scan_word_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire
